// ===== rtl/v3norm_pkg.sv =====
// package for the 3d vector normalise core: payload types and fixed-point constants
`timescale 1ns / 1ps
`default_nettype none
package v3norm_pkg;

    // fraction bits of the unit components
    localparam int OUT_FRAC_BITS = 30;
    // quotient width, the quotient never exceeds 1.0 plus half an lsb
    localparam int QUO_W = OUT_FRAC_BITS + 1;

    // stage map of the pipeline
    localparam int ST_SQRT0  = 6;
    localparam int SQRT_STEPS = 32;
    localparam int ST_DPREP  = ST_SQRT0 + SQRT_STEPS;
    localparam int ST_DIV0   = ST_DPREP + 1;
    localparam int NUM_ST    = ST_DIV0 + QUO_W;

    typedef struct packed {
        logic signed [31:0] comp_x;
        logic signed [31:0] comp_y;
        logic signed [31:0] comp_z;
    } t_vec_in;

    typedef struct packed {
        logic signed [31:0] unit_x;
        logic signed [31:0] unit_y;
        logic signed [31:0] unit_z;
        logic        [31:0] vec_length;
        logic               zero_length;
    } t_vec_out;

endpackage
`default_nettype wire

// ===== rtl/vector3_normalize_core.sv =====
// top level of the 3d vector normalise core: fully pipelined length and unit vector
`timescale 1ns / 1ps
`default_nettype none
// Takes one signed Q16.16 vector per request and returns its length (unsigned Q16.16,
// rounded down) and its unit vector (signed Q2.30, rounded to nearest, ties away from
// zero). A request can enter every cycle while o_stall is low; the core holds 70
// pipeline stages plus the output register, set by the 32 one-bit steps of the square
// root and the 31 one-bit steps of the restoring division. The components are first
// scaled by a common power of two, so the direction keeps full precision for small
// vectors. An all-zero vector gives zeros with zero_length raised. When the result
// register is held by i_stall the whole pipeline freezes and o_stall is raised; nothing
// is lost or repeated.
module vector3_normalize_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output      logic                  o_stall,
    input  wire v3norm_pkg::t_vec_in   i_req,
    output      logic                  o_valid,
    input  wire logic                  i_stall,
    output      v3norm_pkg::t_vec_out  o_res
);
    import v3norm_pkg::*;

    // everything one request carries down the pipeline
    typedef struct packed {
        logic [2:0]            neg;
        logic                  zero;
        logic [2:0][31:0]      mag;
        logic [31:0]           largest;
        logic [2:0][63:0]      prod;
        logic [4:0]            shift;
        logic [63:0]           rem_a;
        logic [63:0]           root_a;
        logic [63:0]           rem_b;
        logic [63:0]           root_b;
        logic [31:0]           slen;
        logic [2:0][63:0]      drem;
        logic [2:0][QUO_W-1:0] quo;
    } t_work;

    t_work            r_st  [NUM_ST];
    logic [NUM_ST-1:0] r_vld;
    t_vec_out         r_out;
    logic             r_out_vld;
    t_vec_out         n_out;
    logic             en;

    // pipeline moves unless a finished result is being held
    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

    // leading zero count, binary search in five narrow steps
    function automatic logic [5:0] lead_zeros(input logic [31:0] x);
        logic [5:0]  n;
        logic [31:0] v;
        n = '0;
        v = x;
        if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
        if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
        if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
        if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
        if (v[31] == 1'b0)  begin n = n + 6'd1;  end
        return n;
    endfunction

    for (genvar s = 0; s < NUM_ST; s++) begin : g_st
        t_work n_st;

        if (s == 0) begin : g_mag
            // magnitude and sign of each component, most negative value taken as 2^31
            always_comb begin
                logic [2:0][31:0] c;
                c = {i_req.comp_x, i_req.comp_y, i_req.comp_z};
                n_st = '0;
                for (int i = 0; i < 3; i++) begin
                    n_st.neg[i] = c[2-i][31];
                    n_st.mag[i] = c[2-i][31] ? (~c[2-i] + 32'd1) : c[2-i];
                end
            end
        end else if (s == 1 || s == 4) begin : g_sq
            // squares of the magnitudes, raw at stage 1 and scaled at stage 4
            always_comb begin
                logic [31:0] big;
                n_st = r_st[s-1];
                for (int i = 0; i < 3; i++) begin
                    n_st.prod[i] = {32'd0, r_st[s-1].mag[i]} * {32'd0, r_st[s-1].mag[i]};
                end
                big = r_st[s-1].mag[0];
                if (r_st[s-1].mag[1] > big) big = r_st[s-1].mag[1];
                if (r_st[s-1].mag[2] > big) big = r_st[s-1].mag[2];
                if (s == 1) begin
                    n_st.largest = big;
                end
            end
        end else if (s == 2) begin : g_sum
            // sum of squares, the common scaling shift and the zero flag
            always_comb begin
                logic [5:0] lz;
                n_st = r_st[s-1];
                n_st.rem_a = r_st[s-1].prod[0] + r_st[s-1].prod[1] + r_st[s-1].prod[2];
                lz = lead_zeros(r_st[s-1].largest);
                n_st.shift = (lz == 6'd0) ? 5'd0 : 5'(lz - 6'd1);
                n_st.zero  = (r_st[s-1].largest == '0);
            end
        end else if (s == 3) begin : g_scale
            always_comb begin
                n_st = r_st[s-1];
                for (int i = 0; i < 3; i++) begin
                    n_st.mag[i] = r_st[s-1].mag[i] << r_st[s-1].shift;
                end
            end
        end else if (s == 5) begin : g_ssum
            always_comb begin
                n_st = r_st[s-1];
                n_st.rem_b  = r_st[s-1].prod[0] + r_st[s-1].prod[1] + r_st[s-1].prod[2];
                n_st.root_a = '0;
                n_st.root_b = '0;
            end
        end else if (s < ST_DPREP) begin : g_sqrt
            // one result bit of both square roots per stage
            localparam int K = s - ST_SQRT0;
            localparam logic [63:0] BITV = 64'd1 << (62 - 2 * K);
            always_comb begin
                n_st = r_st[s-1];
                if (r_st[s-1].rem_a >= r_st[s-1].root_a + BITV) begin
                    n_st.rem_a  = r_st[s-1].rem_a - (r_st[s-1].root_a + BITV);
                    n_st.root_a = (r_st[s-1].root_a >> 1) + BITV;
                end else begin
                    n_st.root_a = r_st[s-1].root_a >> 1;
                end
                if (r_st[s-1].rem_b >= r_st[s-1].root_b + BITV) begin
                    n_st.rem_b  = r_st[s-1].rem_b - (r_st[s-1].root_b + BITV);
                    n_st.root_b = (r_st[s-1].root_b >> 1) + BITV;
                end else begin
                    n_st.root_b = r_st[s-1].root_b >> 1;
                end
            end
        end else if (s == ST_DPREP) begin : g_dprep
            // dividend with half the divisor added for round to nearest
            always_comb begin
                logic [31:0] sl;
                n_st = r_st[s-1];
                sl = r_st[s-1].root_b[31:0];
                n_st.slen = sl;
                for (int i = 0; i < 3; i++) begin
                    n_st.drem[i] = ({32'd0, r_st[s-1].mag[i]} << OUT_FRAC_BITS)
                                 + {33'd0, sl[31:1]};
                    n_st.quo[i]  = '0;
                end
            end
        end else begin : g_div
            // restoring division, one quotient bit per stage for all three lanes
            localparam int B = QUO_W - 1 - (s - ST_DIV0);
            always_comb begin
                logic [63:0] trial;
                n_st = r_st[s-1];
                trial = {32'd0, r_st[s-1].slen} << B;
                for (int i = 0; i < 3; i++) begin
                    if (r_st[s-1].drem[i] >= trial) begin
                        n_st.drem[i]   = r_st[s-1].drem[i] - trial;
                        n_st.quo[i][B] = 1'b1;
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[s] <= n_st;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_ST-2:0], i_valid};
        end
    end

    // clamp to 1.0, restore sign, zero vector override
    always_comb begin
        t_work            w;
        logic [2:0][31:0] u;
        logic [QUO_W-1:0] q;
        w = r_st[NUM_ST-1];
        for (int i = 0; i < 3; i++) begin
            q = w.quo[i];
            if (q > (QUO_W'(1) << OUT_FRAC_BITS)) q = QUO_W'(1) << OUT_FRAC_BITS;
            u[i] = w.neg[i] ? (32'd0 - 32'(q)) : 32'(q);
        end
        n_out.unit_x      = w.zero ? '0 : u[0];
        n_out.unit_y      = w.zero ? '0 : u[1];
        n_out.unit_z      = w.zero ? '0 : u[2];
        n_out.vec_length  = w.zero ? '0 : w.root_a[31:0];
        n_out.zero_length = w.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[NUM_ST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
